// ===== design/i2cbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbc_pkg
// Shared types and constants for the I2C bus-clear sequencer.
// ----------------------------------------------------------------------------
package i2cbc_pkg;

	// sequencer phases
	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_SETTLE  = 4'd1,
		PH_LOW     = 4'd2,
		PH_HIGH    = 4'd3,
		PH_STRETCH = 4'd4,
		PH_START   = 4'd5,
		PH_STOP    = 4'd6
	} phase_t;

	// finish status codes
	localparam logic [1:0] ST_CLEARED   = 2'd0;
	localparam logic [1:0] ST_SCL_LOW   = 2'd1;
	localparam logic [1:0] ST_STRETCH   = 2'd2;
	localparam logic [1:0] ST_SDA_STUCK = 2'd3;

	// configuration register indexes
	localparam int unsigned CFG_IDX_BITS = 3;
	localparam logic [CFG_IDX_BITS-1:0] REG_SETTLE_TICKS   = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_PULSE_TICKS    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_POLL_TICKS     = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_PULSES     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_MAX_POLLS      = 3'd4;
	localparam int unsigned CFG_DATA_BITS = 24;

	// configuration reset values
	localparam logic [23:0] SETTLE_TICKS_RST = 24'd2500000;
	localparam logic [15:0] PULSE_TICKS_RST  = 16'd10;
	localparam logic [23:0] POLL_TICKS_RST   = 24'd100000;
	localparam logic [4:0]  MAX_PULSES_RST   = 5'd20;
	localparam logic [4:0]  MAX_POLLS_RST    = 5'd20;

	typedef struct packed {
		logic [23:0] settle_ticks;
		logic [15:0] pulse_ticks;
		logic [23:0] stretch_poll_ticks;
		logic [4:0]  max_pulses;
		logic [4:0]  max_stretch_polls;
	} cfg_t;

	typedef struct packed {
		logic op;
		logic scl_in;
		logic sda_in;
	} in_item_t;

	typedef struct packed {
		logic       scl_drive_low;
		logic       sda_drive_low;
		logic       busy_res;
		logic       done_res;
		logic [1:0] status;
	} out_item_t;

endpackage

// ===== design/i2cbc_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbc_core
// Sequencer state and the per-tick step: one beat advances the state once.
// ----------------------------------------------------------------------------
module i2cbc_core import i2cbc_pkg::*; #(
	parameter int unsigned TIMER_BITS = 24
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      step,
	input  in_item_t  item,
	input  cfg_t      cfg,
	output out_item_t result
);

	localparam logic [32:0] TIMER_MAX = (33'd1 << TIMER_BITS) - 33'd1;

	// saturate a load value to the timer range
	function automatic logic [TIMER_BITS-1:0] sat_load(input logic [32:0] v);
		logic [TIMER_BITS-1:0] r;
		if (v > TIMER_MAX) begin
			r = TIMER_MAX[TIMER_BITS-1:0];
		end else begin
			r = v[TIMER_BITS-1:0];
		end
		return r;
	endfunction

	// interval loads: value minus one, zero stays zero
	function automatic logic [TIMER_BITS-1:0] int_load(input logic [23:0] v);
		logic [32:0] m;
		m = (v == 24'd0) ? 33'd0 : (33'(v) - 33'd1);
		return sat_load(m);
	endfunction

	phase_t                phase_q,  phase_d;
	logic [TIMER_BITS-1:0] wait_q,   wait_d;
	logic [4:0]            pulses_q, pulses_d;
	logic [4:0]            polls_q,  polls_d;
	logic [1:0]            status_q, status_d;
	logic                  done_d;
	logic [4:0]            polls_cur;
	logic [TIMER_BITS-1:0] pulse_load;
	logic [TIMER_BITS-1:0] poll_load;
	logic [TIMER_BITS-1:0] settle_load;

	assign pulse_load  = int_load({8'd0, cfg.pulse_ticks});
	assign poll_load   = int_load(cfg.stretch_poll_ticks);
	assign settle_load = sat_load(33'(cfg.settle_ticks));
	assign polls_cur   = (phase_q == PH_HIGH) ? cfg.max_stretch_polls : polls_q;

	// next state for one tick
	always_comb begin
		phase_d  = phase_q;
		wait_d   = wait_q;
		pulses_d = pulses_q;
		polls_d  = polls_q;
		status_d = status_q;
		done_d   = 1'b0;
		if (phase_q == PH_IDLE) begin
			if (item.op) begin
				phase_d  = PH_SETTLE;
				wait_d   = settle_load;
				pulses_d = cfg.max_pulses;
				polls_d  = 5'd0;
			end
		end else if (wait_q != '0) begin
			wait_d = wait_q - TIMER_BITS'(1);
		end else begin
			case (phase_q)
				PH_SETTLE: begin
					if (!item.scl_in) begin
						phase_d  = PH_IDLE;
						wait_d   = '0;
						status_d = ST_SCL_LOW;
						done_d   = 1'b1;
					end else if (item.sda_in) begin
						phase_d = PH_START;
						wait_d  = pulse_load;
					end else if (pulses_q == 5'd0) begin
						phase_d  = PH_IDLE;
						wait_d   = '0;
						status_d = ST_SDA_STUCK;
						done_d   = 1'b1;
					end else begin
						pulses_d = pulses_q - 5'd1;
						phase_d  = PH_LOW;
						wait_d   = pulse_load;
					end
				end
				PH_LOW: begin
					phase_d = PH_HIGH;
					wait_d  = pulse_load;
				end
				PH_HIGH, PH_STRETCH: begin
					polls_d = polls_cur;
					if (item.scl_in) begin
						if (item.sda_in) begin
							phase_d = PH_START;
							wait_d  = pulse_load;
						end else if (pulses_q == 5'd0) begin
							phase_d  = PH_IDLE;
							wait_d   = '0;
							status_d = ST_SDA_STUCK;
							done_d   = 1'b1;
						end else begin
							pulses_d = pulses_q - 5'd1;
							phase_d  = PH_LOW;
							wait_d   = pulse_load;
						end
					end else if (polls_cur == 5'd0) begin
						phase_d  = PH_IDLE;
						wait_d   = '0;
						status_d = ST_STRETCH;
						done_d   = 1'b1;
					end else begin
						polls_d = polls_cur - 5'd1;
						phase_d = PH_STRETCH;
						wait_d  = poll_load;
					end
				end
				PH_START: begin
					phase_d = PH_STOP;
					wait_d  = pulse_load;
				end
				default: begin
					phase_d  = PH_IDLE;
					wait_d   = '0;
					status_d = ST_CLEARED;
					done_d   = 1'b1;
				end
			endcase
		end
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			wait_q   <= '0;
			pulses_q <= 5'd0;
			polls_q  <= 5'd0;
			status_q <= ST_CLEARED;
		end else if (step) begin
			phase_q  <= phase_d;
			wait_q   <= wait_d;
			pulses_q <= pulses_d;
			polls_q  <= polls_d;
			status_q <= status_d;
		end
	end

	// result of this tick, taken from the next state
	always_comb begin
		result.scl_drive_low = (phase_d == PH_LOW);
		result.sda_drive_low = (phase_d == PH_START);
		result.busy_res      = (phase_d != PH_IDLE);
		result.done_res      = done_d;
		result.status        = status_d;
	end

endmodule

// ===== design/i2c_bus_clear_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bus_clear_sequencer
// I2C bus recovery: settle, SCL pulses while SDA is stuck, then start/stop.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall/in_data): one beat per timing tick, op=1
//   starts the recovery, op=0 is a plain tick; scl_in/sda_in are the sampled
//   bus levels for that tick.
//   Output channel (out_valid/out_stall/out_data): exactly one result beat per
//   input beat, in order, with the line drives, busy, done and status.
//   Configuration: cfg_we writes cfg_data into register cfg_index (settle,
//   pulse, poll interval, max pulses, max polls); write only while idle.
// Timing:
//   One beat per clock sustained while out_stall is low. A beat passes the
//   input register, then the sequencer step, then the result register.
//   When out_stall holds a result, the input register still takes one more
//   beat; after that in_stall rises until the result register drains.
// Reset:
//   arst_n clears both pipeline stages, returns the sequencer to idle with
//   status 0 and loads the configuration reset values.
// ----------------------------------------------------------------------------
module i2c_bus_clear_sequencer import i2cbc_pkg::*; #(
	parameter int unsigned TIMER_BITS = 24
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  in_item_t                 in_data,
	output logic                     out_valid,
	input  logic                     out_stall,
	output out_item_t                out_data,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	cfg_t      cfg_q;
	logic      valid_s1;
	in_item_t  item_s1;
	logic      valid_s2;
	out_item_t res_s2;
	out_item_t res_comb;
	logic      advance;
	logic      take_in;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.settle_ticks       <= SETTLE_TICKS_RST;
			cfg_q.pulse_ticks        <= PULSE_TICKS_RST;
			cfg_q.stretch_poll_ticks <= POLL_TICKS_RST;
			cfg_q.max_pulses         <= MAX_PULSES_RST;
			cfg_q.max_stretch_polls  <= MAX_POLLS_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SETTLE_TICKS: cfg_q.settle_ticks       <= cfg_data;
				REG_PULSE_TICKS:  cfg_q.pulse_ticks        <= cfg_data[15:0];
				REG_POLL_TICKS:   cfg_q.stretch_poll_ticks <= cfg_data;
				REG_MAX_PULSES:   cfg_q.max_pulses         <= cfg_data[4:0];
				REG_MAX_POLLS:    cfg_q.max_stretch_polls  <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// handshake: step when the result register is free or draining
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= in_data;
		end
	end

	i2cbc_core #(
		.TIMER_BITS(TIMER_BITS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg_q),
		.result (res_comb)
	);

	// result stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_comb;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = res_s2;

endmodule

// ===== design/i2cbc_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbc_checker
// Port-level checks for the bus-clear sequencer, bound to the top level.
// ----------------------------------------------------------------------------
module i2cbc_checker import i2cbc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_stall,
	input in_item_t  in_data,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_data
);

	// a finishing beat leaves the sequencer idle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.done_res |-> !out_data.busy_res)
	else $error("done beat still reports busy");

	// line drives only while the sequence runs
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_data.scl_drive_low || out_data.sda_drive_low)
		|-> out_data.busy_res)
	else $error("line driven while idle");

	// never pull both lines at once
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.scl_drive_low && out_data.sda_drive_low))
	else $error("SCL and SDA driven low together");

	// a stalled result beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
	else $error("stalled result beat changed");

	// a stalled input beat holds
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_data))
	else $error("stalled input beat changed");

endmodule

bind i2c_bus_clear_sequencer i2cbc_checker u_i2cbc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ===== bench/i2c_bus_clear_sequencer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bus_clear_sequencer_tb
// Self-checking bench for the I2C bus-clear sequencer. An in-bench predictor
// tracks phase, timers and pulse/poll budgets per accepted tick and compares
// every result beat field by field. Directed cases cover each finish status
// and the zero-budget corners. Random rounds reprogram the timing registers
// and run recovery sequences against biased SCL/SDA line levels. The sender
// idles in bursts and the receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module i2c_bus_clear_sequencer_tb import i2cbc_pkg::*; ();

	localparam int unsigned TIMER_BITS = 24;
	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam int unsigned RANDOM_ITEMS = 780;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	in_item_t                 in_data = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	out_item_t                out_data;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	i2c_bus_clear_sequencer #(
		.TIMER_BITS(TIMER_BITS)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #4 clk = ~clk;

	// predictor state, starting from the reset values
	cfg_t                  seq_cfg = '{SETTLE_TICKS_RST, PULSE_TICKS_RST, POLL_TICKS_RST,
		MAX_PULSES_RST, MAX_POLLS_RST};
	phase_t                seq_phase = PH_IDLE;
	logic [TIMER_BITS-1:0] seq_wait = '0;
	logic [4:0]            pulses_left = '0;
	logic [4:0]            polls_left = '0;
	logic [1:0]            last_status = ST_CLEARED;
	logic                  done_now = 1'b0;

	out_item_t   predicted_results[$];
	out_item_t   head_result;
	int unsigned err_count = 0;
	int unsigned burst_left = 0;
	int unsigned stall_run = 0;

	function automatic logic [TIMER_BITS-1:0] clamp_timer(input logic [31:0] v);
		return (v > TIMER_MAX) ? TIMER_MAX : v[TIMER_BITS-1:0];
	endfunction

	// a half period or poll interval of n items loads n-1, zero acts as one
	function automatic logic [TIMER_BITS-1:0] interval_load(input logic [31:0] v);
		return clamp_timer((v == 0) ? 32'd0 : v - 32'd1);
	endfunction

	function automatic void finish_seq(input logic [1:0] st);
		seq_phase   = PH_IDLE;
		seq_wait    = '0;
		last_status = st;
		done_now    = 1'b1;
	endfunction

	// SCL is high: either start/stop if SDA is free, or pulse again
	function automatic void sample_sda(input logic sda);
		if (sda) begin
			seq_phase = PH_START;
			seq_wait  = interval_load(32'(seq_cfg.pulse_ticks));
		end else if (pulses_left == 0) begin
			finish_seq(ST_SDA_STUCK);
		end else begin
			pulses_left = pulses_left - 5'd1;
			seq_phase   = PH_LOW;
			seq_wait    = interval_load(32'(seq_cfg.pulse_ticks));
		end
	endfunction

	// after a pulse, wait out clock stretching with bounded polls
	function automatic void poll_scl(input logic scl, input logic sda);
		if (scl) begin
			sample_sda(sda);
		end else if (polls_left == 0) begin
			finish_seq(ST_STRETCH);
		end else begin
			polls_left = polls_left - 5'd1;
			seq_phase  = PH_STRETCH;
			seq_wait   = interval_load(32'(seq_cfg.stretch_poll_ticks));
		end
	endfunction

	// advance the sequencer by one accepted beat and form its result
	function automatic out_item_t step_recovery(input in_item_t b);
		out_item_t r;
		done_now = 1'b0;
		if (seq_phase == PH_IDLE) begin
			if (b.op) begin
				seq_phase   = PH_SETTLE;
				seq_wait    = clamp_timer(32'(seq_cfg.settle_ticks));
				pulses_left = seq_cfg.max_pulses;
				polls_left  = '0;
			end
		end else if (seq_wait != 0) begin
			seq_wait = seq_wait - TIMER_BITS'(1);
		end else begin
			case (seq_phase)
				PH_SETTLE: begin
					if (!b.scl_in)
						finish_seq(ST_SCL_LOW);
					else
						sample_sda(b.sda_in);
				end
				PH_LOW: begin
					seq_phase = PH_HIGH;
					seq_wait  = interval_load(32'(seq_cfg.pulse_ticks));
				end
				PH_HIGH: begin
					polls_left = seq_cfg.max_stretch_polls;
					poll_scl(b.scl_in, b.sda_in);
				end
				PH_STRETCH: begin
					poll_scl(b.scl_in, b.sda_in);
				end
				PH_START: begin
					seq_phase = PH_STOP;
					seq_wait  = interval_load(32'(seq_cfg.pulse_ticks));
				end
				default: begin
					finish_seq(ST_CLEARED);
				end
			endcase
		end
		r.scl_drive_low = (seq_phase == PH_LOW);
		r.sda_drive_low = (seq_phase == PH_START);
		r.busy_res      = (seq_phase != PH_IDLE);
		r.done_res      = done_now;
		r.status        = last_status;
		return r;
	endfunction

	function automatic cfg_t make_cfg(input logic [23:0] settle, input logic [15:0] pulse,
		input logic [23:0] poll, input logic [4:0] npulse, input logic [4:0] npoll);
		cfg_t c;
		c.settle_ticks       = settle;
		c.pulse_ticks        = pulse;
		c.stretch_poll_ticks = poll;
		c.max_pulses         = npulse;
		c.max_stretch_polls  = npoll;
		return c;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_val,
		input int unsigned got_val);
		if (exp_val != got_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, got_val);
			err_count++;
		end
	endfunction

	// register writes, only issued while the sequencer is idle and drained
	task automatic write_regs(input cfg_t c, input logic [4:0] sel);
		logic [CFG_IDX_BITS-1:0]  idx;
		logic [CFG_DATA_BITS-1:0] data;
		for (int i = 0; i < 5; i++) begin
			if (sel[i]) begin
				idx = i[CFG_IDX_BITS-1:0];
				case (idx)
					REG_SETTLE_TICKS: begin
						data = c.settle_ticks;
						seq_cfg.settle_ticks = c.settle_ticks;
					end
					REG_PULSE_TICKS: begin
						data = CFG_DATA_BITS'(c.pulse_ticks);
						seq_cfg.pulse_ticks = c.pulse_ticks;
					end
					REG_POLL_TICKS: begin
						data = c.stretch_poll_ticks;
						seq_cfg.stretch_poll_ticks = c.stretch_poll_ticks;
					end
					REG_MAX_PULSES: begin
						data = CFG_DATA_BITS'(c.max_pulses);
						seq_cfg.max_pulses = c.max_pulses;
					end
					default: begin
						data = CFG_DATA_BITS'(c.max_stretch_polls);
						seq_cfg.max_stretch_polls = c.max_stretch_polls;
					end
				endcase
				cfg_we    <= 1'b1;
				cfg_index <= idx;
				cfg_data  <= data;
				@(posedge clk);
			end
		end
		cfg_we <= 1'b0;
	endtask

	// one input beat, with bursty idling ahead of it
	task automatic send_beat(input logic op, input logic scl, input logic sda);
		in_item_t    b;
		out_item_t   exp_res;
		int unsigned gap;
		b.op     = op;
		b.scl_in = scl;
		b.sda_in = sda;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
				: $urandom_range(1, 30);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data  <= b;
		do @(posedge clk); while (in_stall);
		exp_res = step_recovery(b);
		predicted_results = {predicted_results, exp_res};
	endtask

	// hold off the sender until every predicted result has come back
	task automatic wait_results;
		in_valid <= 1'b0;
		burst_left = 0;
		while (predicted_results.size() != 0) @(posedge clk);
	endtask

	// start, then tick with biased line levels until the sequence finishes
	task automatic run_sequence(input int unsigned scl_low_pct, input int unsigned sda_low_pct,
		output int unsigned n);
		send_beat(1'b1, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		n = 1;
		while (seq_phase != PH_IDLE) begin
			send_beat($urandom_range(0, 19) == 0, $urandom_range(0, 99) >= scl_low_pct,
				$urandom_range(0, 99) >= sda_low_pct);
			n++;
		end
	endtask

	task automatic test_idle_after_reset;
		send_beat(1'b0, 1'b0, 1'b1);
		send_beat(1'b0, 1'b1, 1'b0);
	endtask

	// only settle rewritten, the rest keep their reset values
	task automatic test_settle_only;
		wait_results();
		write_regs(make_cfg(24'd1, 16'd0, 24'd0, 5'd0, 5'd0), 5'b00001);
		send_beat(1'b1, 1'b1, 1'b1);
		send_beat(1'b0, 1'b1, 1'b1);
		send_beat(1'b0, 1'b0, 1'b1);
	endtask

	task automatic test_scl_held_low;
		wait_results();
		write_regs(make_cfg(24'd0, 16'd0, 24'd0, 5'd0, 5'd0), 5'b11111);
		send_beat(1'b1, 1'b0, 1'b0);
		send_beat(1'b0, 1'b0, 1'b1);
	endtask

	// no pulse budget: SDA low at the first check gives up at once
	task automatic test_sda_stuck_no_pulses;
		send_beat(1'b1, 1'b1, 1'b1);
		send_beat(1'b0, 1'b1, 1'b0);
	endtask

	// no poll budget: SCL low after the pulse times out at once
	task automatic test_stretch_no_polls;
		wait_results();
		write_regs(make_cfg(24'd0, 16'd0, 24'd0, 5'd1, 5'd0), 5'b11111);
		send_beat(1'b1, 1'b0, 1'b0);
		send_beat(1'b0, 1'b1, 1'b0);
		send_beat(1'b0, 1'b0, 1'b0);
		send_beat(1'b0, 1'b0, 1'b1);
	endtask

	// clean finish, with a start request arriving mid-sequence
	task automatic test_clear_with_restart;
		send_beat(1'b1, 1'b1, 1'b0);
		send_beat(1'b0, 1'b1, 1'b1);
		send_beat(1'b1, 1'b0, 1'b0);
		send_beat(1'b0, 1'b0, 1'b0);
	endtask

	// one pulse, one stretch poll, then the bus frees up
	task automatic test_stretch_recovery;
		wait_results();
		write_regs(make_cfg(24'd1, 16'd1, 24'd1, 5'd2, 5'd2), 5'b11111);
		send_beat(1'b1, 1'b0, 1'b0);
		send_beat(1'b0, 1'b0, 1'b0);
		send_beat(1'b0, 1'b1, 1'b0);
		send_beat(1'b0, 1'b1, 1'b0);
		send_beat(1'b0, 1'b0, 1'b1);
		send_beat(1'b0, 1'b1, 1'b1);
		send_beat(1'b0, 1'b0, 1'b0);
		send_beat(1'b0, 1'b1, 1'b0);
	endtask

	// random short timings, random line behavior per sequence
	task automatic test_random_sequences;
		cfg_t        c;
		int unsigned sent;
		int unsigned n;
		int unsigned scl_pct;
		int unsigned sda_pct;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_results();
			c = make_cfg(24'($urandom_range(0, 6)), 16'($urandom_range(0, 4)),
				24'($urandom_range(0, 3)),
				($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(0, 6)),
				($urandom_range(0, 4) == 0) ? 5'($urandom_range(0, 31))
					: 5'($urandom_range(0, 5)));
			write_regs(c, 5'b11111);
			repeat ($urandom_range(2, 6)) begin
				if (sent < RANDOM_ITEMS) begin
					// ignored ticks while idle
					repeat ($urandom_range(0, 2))
						send_beat(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
					case ($urandom_range(0, 4))
						0, 1:    scl_pct = 0;
						2:       scl_pct = 10;
						3:       scl_pct = 40;
						default: scl_pct = 90;
					endcase
					case ($urandom_range(0, 3))
						0:       sda_pct = 0;
						1:       sda_pct = 40;
						2:       sda_pct = 80;
						default: sda_pct = 100;
					endcase
					run_sequence(scl_pct, sda_pct, n);
					sent += n;
				end
			end
		end
	endtask

	// widest register values; the sequence is left counting down
	task automatic test_long_timers;
		wait_results();
		write_regs(make_cfg(24'hFFFFFF, 16'hFFFF, 24'hFFFFFF, 5'd31, 5'd31), 5'b11111);
		send_beat(1'b1, 1'b1, 1'b0);
		repeat (40) send_beat(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
			1'($urandom_range(0, 1)));
	endtask

	// receiver stall pattern: quiet stretches, stall runs and fine toggling
	always @(posedge clk) begin
		if (stall_run == 0) begin
			case ($urandom_range(0, 7))
				0: begin
					out_stall <= 1'b0;
					stall_run = $urandom_range(50, 150);
				end
				1, 2: begin
					out_stall <= 1'b1;
					stall_run = $urandom_range(1, 8);
				end
				default: begin
					out_stall <= 1'b0;
					stall_run = $urandom_range(1, 6);
				end
			endcase
		end else begin
			stall_run--;
		end
	end

	// result checker, one beat per accepted output
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (predicted_results.size() == 0) begin
				$error("result beat with nothing predicted: %p", out_data);
				err_count++;
			end else begin
				head_result = predicted_results.pop_front();
				check_field("scl_drive_low", head_result.scl_drive_low, out_data.scl_drive_low);
				check_field("sda_drive_low", head_result.sda_drive_low, out_data.sda_drive_low);
				check_field("busy_res", head_result.busy_res, out_data.busy_res);
				check_field("done_res", head_result.done_res, out_data.done_res);
				check_field("status", head_result.status, out_data.status);
			end
		end
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_idle_after_reset();
		test_settle_only();
		test_scl_held_low();
		test_sda_stuck_no_pulses();
		test_stretch_no_polls();
		test_clear_with_restart();
		test_stretch_recovery();
		test_random_sequences();
		test_long_timers();
		wait_results();
		repeat (8) @(posedge clk);
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// run limit
	initial begin
		#5_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
